// File: hdl/dual_vfo_tuning_register_assert.svh
// Assertion macros shared by the checkers of the dual VFO tuning register.
// Depends on nothing; the using scope provides clk and arst_n.
`ifndef DUAL_VFO_TUNING_REGISTER_ASSERT_SVH
`define DUAL_VFO_TUNING_REGISTER_ASSERT_SVH

// Condition implies consequence in the same cycle
`define DVFO_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dual VFO check failed in the same cycle");

// Condition implies consequence in the next cycle
`define DVFO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dual VFO check failed in the next cycle");

`endif

// File: hdl/dvfo_pkg.sv
// Shared types, codes and constants of the dual VFO tuning register.
// No dependencies; used by every module of the block.
package dvfo_pkg;

	// Frequency range and field widths
	localparam int unsigned FREQ_MAX  = 99999999;
	localparam int FREQ_W    = 27;
	localparam int STEP_W    = 24;
	localparam int SHIFT_W   = 28;
	localparam int WORK_W    = 29;
	localparam int CFG_IDX_W = 4;
	localparam int DIGITS    = 8;
	localparam int BCD_W     = 4 * DIGITS;

	// Binary to BCD conversion runs one bit a cycle
	localparam int CONV_STEPS = FREQ_W;
	localparam int CNT_W      = $clog2(CONV_STEPS);

	// Item modes
	localparam logic [1:0] MODE_TUNE     = 2'd0;
	localparam logic [1:0] MODE_LOAD     = 2'd1;
	localparam logic [1:0] MODE_FOCUS    = 2'd2;
	localparam logic [1:0] MODE_TRANSMIT = 2'd3;

	// Shift modes
	localparam logic [1:0] SHIFT_NONE  = 2'd0;
	localparam logic [1:0] SHIFT_PLUS  = 2'd1;
	localparam logic [1:0] SHIFT_MINUS = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STEP_A     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_B     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_A      = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_B      = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_A     = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_B     = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_A   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_B   = 4'd7;

	// Register reset values
	localparam logic [STEP_W-1:0] STEP_RESET = 24'd100;
	localparam logic [FREQ_W-1:0] LOW_RESET  = 27'd0;
	localparam logic [FREQ_W-1:0] HIGH_RESET = 27'd99999999;

	// Controller states
	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_UP     = 10'b0000000010,
		S_DOWN   = 10'b0000000100,
		S_HI     = 10'b0000001000,
		S_LO     = 10'b0000010000,
		S_MAX    = 10'b0000100000,
		S_COMMIT = 10'b0001000000,
		S_SHIFT  = 10'b0010000000,
		S_CONV   = 10'b0100000000,
		S_DONE   = 10'b1000000000
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic add_step;
		logic sub_step;
		logic clamp_hi;
		logic clamp_lo;
		logic clamp_max;
		logic commit;
		logic shift_load;
		logic conv_step;
		logic emit;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic is_tune;
	} stat_t;

endpackage

// File: hdl/dvfo_ctrl.sv
// Controller state machine of the dual VFO tuning register.
// Depends on dvfo_pkg; drives the datapath through cmd_t.
module dvfo_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  dvfo_pkg::stat_t stat,
	output dvfo_pkg::cmd_t  cmd,
	output logic            busy
);

	dvfo_pkg::state_t                 state_q, state_d;
	logic [dvfo_pkg::CNT_W-1:0]       cnt_q, cnt_d;

	// Hold state and conversion count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dvfo_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Sequence the item through tune, commit, shift, conversion and output
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			dvfo_pkg::S_IDLE: begin
				cmd.capture = start;
				if (start) state_d = dvfo_pkg::S_UP;
			end
			dvfo_pkg::S_UP: begin
				if (stat.is_tune) begin
					cmd.add_step = 1'b1;
					state_d      = dvfo_pkg::S_DOWN;
				end else begin
					state_d = dvfo_pkg::S_COMMIT;
				end
			end
			dvfo_pkg::S_DOWN: begin
				cmd.sub_step = 1'b1;
				state_d      = dvfo_pkg::S_HI;
			end
			dvfo_pkg::S_HI: begin
				cmd.clamp_hi = 1'b1;
				state_d      = dvfo_pkg::S_LO;
			end
			dvfo_pkg::S_LO: begin
				cmd.clamp_lo = 1'b1;
				state_d      = dvfo_pkg::S_MAX;
			end
			dvfo_pkg::S_MAX: begin
				cmd.clamp_max = 1'b1;
				state_d       = dvfo_pkg::S_COMMIT;
			end
			dvfo_pkg::S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = dvfo_pkg::S_SHIFT;
			end
			dvfo_pkg::S_SHIFT: begin
				cmd.shift_load = 1'b1;
				cnt_d          = '0;
				state_d        = dvfo_pkg::S_CONV;
			end
			dvfo_pkg::S_CONV: begin
				cmd.conv_step = 1'b1;
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == dvfo_pkg::CNT_W'(dvfo_pkg::CONV_STEPS - 1))
					state_d = dvfo_pkg::S_DONE;
			end
			dvfo_pkg::S_DONE: begin
				cmd.emit = 1'b1;
				state_d  = dvfo_pkg::S_IDLE;
			end
			default: begin
				state_d = dvfo_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != dvfo_pkg::S_IDLE);

endmodule

// File: hdl/dvfo_datapath.sv
// Datapath of the dual VFO tuning register: registers, stores, tuning
// arithmetic, shift and binary to BCD conversion. Depends on dvfo_pkg.
module dvfo_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dvfo_pkg::cmd_t                       cmd,
	output dvfo_pkg::stat_t                      stat,
	// item fields
	input  logic [1:0]                           mode,
	input  logic                                 vfo_index,
	input  logic                                 turn_up,
	input  logic                                 turn_down,
	input  logic [dvfo_pkg::FREQ_W-1:0]          load_freq,
	input  logic [1:0]                           offset_select,
	input  logic                                 transmit_on,
	// register writes
	input  logic                                 cfg_write,
	input  logic [dvfo_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dvfo_pkg::FREQ_W-1:0]          cfg_data,
	// results
	output logic                                 result_valid,
	output logic                                 reported_vfo,
	output logic [dvfo_pkg::FREQ_W-1:0]          dial_freq,
	output logic signed [dvfo_pkg::SHIFT_W-1:0]  shifted_freq,
	output logic                                 freq_changed,
	output logic                                 transmit_changed,
	output logic [6:0]                           digit_millions,
	output logic [3:0]                           digit_hundred_k,
	output logic [3:0]                           digit_ten_k,
	output logic [3:0]                           digit_thousands,
	output logic [3:0]                           digit_hundreds,
	output logic [3:0]                           digit_tens,
	output logic [3:0]                           digit_ones
);

	localparam int FW = dvfo_pkg::FREQ_W;
	localparam int SW = dvfo_pkg::STEP_W;
	localparam int WW = dvfo_pkg::WORK_W;
	localparam int HW = dvfo_pkg::SHIFT_W;
	localparam int BW = dvfo_pkg::BCD_W;

	// Configuration registers
	logic [SW-1:0] step_q   [2];
	logic [FW-1:0] low_q    [2];
	logic [FW-1:0] high_q   [2];
	logic [SW-1:0] offset_q [2];

	// Model state
	logic [FW-1:0] dial_q  [2];
	logic [FW-1:0] last_q  [2];
	logic [1:0]    omode_q [2];
	logic          focus_q;
	logic          tx_q;

	// Captured item
	logic [1:0]    mode_q;
	logic          vsel_q;
	logic          up_q;
	logic          down_q;
	logic [FW-1:0] lf_q;
	logic [1:0]    osel_q;
	logic          txon_q;

	// Working values
	logic signed [WW-1:0] x_q;
	logic                 rep_q;
	logic                 fchg_q;
	logic                 tchg_q;
	logic signed [HW-1:0] sh_q;
	logic [FW-1:0]        bin_q;
	logic [BW-1:0]        bcd_q;
	logic [FW-1:0]        dout_q;

	// Output registers
	logic                 valid_q;
	logic                 rep_out_q;
	logic [FW-1:0]        dial_out_q;
	logic signed [HW-1:0] sh_out_q;
	logic                 fchg_out_q;
	logic                 tchg_out_q;
	logic [6:0]           mil_q;
	logic [3:0]           dig_q [6];

	logic signed [WW-1:0] dial_focus;
	logic signed [WW-1:0] step_focus;
	logic signed [WW-1:0] high_focus;
	logic signed [WW-1:0] low_focus;
	logic [FW-1:0]        tuned;
	logic [FW-1:0]        loaded;
	logic signed [HW-1:0] dial_rep;
	logic signed [HW-1:0] off_rep;
	logic [BW-1:0]        bcd_adj;

	assign stat.is_tune = (mode_q == dvfo_pkg::MODE_TUNE);

	assign dial_focus = $signed({2'b00, dial_q[focus_q]});
	assign step_focus = $signed({{(WW-SW){1'b0}}, step_q[focus_q]});
	assign high_focus = $signed({2'b00, high_q[focus_q]});
	assign low_focus  = $signed({2'b00, low_q[focus_q]});
	assign tuned      = x_q[FW-1:0];
	assign loaded     = (lf_q > FW'(dvfo_pkg::FREQ_MAX)) ? FW'(dvfo_pkg::FREQ_MAX) : lf_q;
	assign dial_rep   = $signed({1'b0, dial_q[rep_q]});
	assign off_rep    = $signed({{(HW-SW){1'b0}}, offset_q[rep_q]});

	// Add three to every digit of five or more before the shift
	always_comb begin
		for (int d = 0; d < dvfo_pkg::DIGITS; d++) begin
			if (bcd_q[4*d +: 4] >= 4'd5) bcd_adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
			else bcd_adj[4*d +: 4] = bcd_q[4*d +: 4];
		end
	end

	// Write configuration registers while idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q[0]   <= dvfo_pkg::STEP_RESET;
			step_q[1]   <= dvfo_pkg::STEP_RESET;
			low_q[0]    <= dvfo_pkg::LOW_RESET;
			low_q[1]    <= dvfo_pkg::LOW_RESET;
			high_q[0]   <= dvfo_pkg::HIGH_RESET;
			high_q[1]   <= dvfo_pkg::HIGH_RESET;
			offset_q[0] <= '0;
			offset_q[1] <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				dvfo_pkg::REG_STEP_A:   step_q[0]   <= cfg_data[SW-1:0];
				dvfo_pkg::REG_STEP_B:   step_q[1]   <= cfg_data[SW-1:0];
				dvfo_pkg::REG_LOW_A:    low_q[0]    <= cfg_data;
				dvfo_pkg::REG_LOW_B:    low_q[1]    <= cfg_data;
				dvfo_pkg::REG_HIGH_A:   high_q[0]   <= cfg_data;
				dvfo_pkg::REG_HIGH_B:   high_q[1]   <= cfg_data;
				dvfo_pkg::REG_OFFSET_A: offset_q[0] <= cfg_data[SW-1:0];
				dvfo_pkg::REG_OFFSET_B: offset_q[1] <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	// Update the stores when an item commits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dial_q[0]  <= '0;
			dial_q[1]  <= '0;
			last_q[0]  <= '0;
			last_q[1]  <= '0;
			omode_q[0] <= dvfo_pkg::SHIFT_NONE;
			omode_q[1] <= dvfo_pkg::SHIFT_NONE;
			focus_q    <= 1'b0;
			tx_q       <= 1'b0;
		end else if (cmd.commit) begin
			unique case (mode_q)
				dvfo_pkg::MODE_TUNE: begin
					dial_q[focus_q] <= tuned;
					last_q[focus_q] <= tuned;
				end
				dvfo_pkg::MODE_LOAD: begin
					dial_q[vsel_q]  <= loaded;
					last_q[vsel_q]  <= loaded;
					omode_q[vsel_q] <= osel_q;
				end
				dvfo_pkg::MODE_FOCUS: begin
					focus_q <= vsel_q;
				end
				dvfo_pkg::MODE_TRANSMIT: begin
					tx_q <= txon_q;
				end
				default: ;
			endcase
		end
	end

	// Capture the item, tune, clamp and convert
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			vsel_q <= vfo_index;
			up_q   <= turn_up;
			down_q <= turn_down;
			lf_q   <= load_freq;
			osel_q <= offset_select;
			txon_q <= transmit_on;
		end
		if (cmd.add_step)
			x_q <= up_q ? dial_focus + step_focus : dial_focus;
		if (cmd.sub_step && down_q)
			x_q <= x_q - step_focus;
		if (cmd.clamp_hi && (x_q > high_focus))
			x_q <= high_focus;
		if (cmd.clamp_lo && (x_q < low_focus))
			x_q <= low_focus;
		if (cmd.clamp_max && (x_q > $signed(WW'(dvfo_pkg::FREQ_MAX))))
			x_q <= $signed(WW'(dvfo_pkg::FREQ_MAX));
		if (cmd.commit) begin
			unique case (mode_q)
				dvfo_pkg::MODE_TUNE: begin
					rep_q  <= focus_q;
					fchg_q <= (tuned != last_q[focus_q]);
					tchg_q <= 1'b0;
				end
				dvfo_pkg::MODE_LOAD: begin
					rep_q  <= vsel_q;
					fchg_q <= 1'b0;
					tchg_q <= 1'b0;
				end
				dvfo_pkg::MODE_FOCUS: begin
					rep_q  <= vsel_q;
					fchg_q <= 1'b0;
					tchg_q <= 1'b0;
				end
				dvfo_pkg::MODE_TRANSMIT: begin
					rep_q  <= focus_q;
					fchg_q <= 1'b0;
					tchg_q <= (txon_q != tx_q);
				end
				default: ;
			endcase
		end
		// Apply the shift and load the converter
		if (cmd.shift_load) begin
			case (omode_q[rep_q])
				dvfo_pkg::SHIFT_PLUS:  sh_q <= dial_rep + off_rep;
				dvfo_pkg::SHIFT_MINUS: sh_q <= dial_rep - off_rep;
				default:               sh_q <= dial_rep;
			endcase
			dout_q <= dial_q[rep_q];
			bin_q  <= dial_q[rep_q];
			bcd_q  <= '0;
		end
		// Shift one bit into the BCD digits
		if (cmd.conv_step) begin
			bcd_q <= {bcd_adj[BW-2:0], bin_q[FW-1]};
			bin_q <= {bin_q[FW-2:0], 1'b0};
		end
	end

	// Register the result fields
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rep_out_q  <= rep_q;
			dial_out_q <= dout_q;
			sh_out_q   <= sh_q;
			fchg_out_q <= fchg_q;
			tchg_out_q <= tchg_q;
			mil_q      <= 7'(bcd_q[31:28]) * 7'd10 + 7'(bcd_q[27:24]);
			for (int d = 0; d < 6; d++) dig_q[d] <= bcd_q[4*d +: 4];
		end
	end

	// Strobe the result for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else valid_q <= cmd.emit;
	end

	assign result_valid     = valid_q;
	assign reported_vfo     = rep_out_q;
	assign dial_freq        = dial_out_q;
	assign shifted_freq     = sh_out_q;
	assign freq_changed     = fchg_out_q;
	assign transmit_changed = tchg_out_q;
	assign digit_millions   = mil_q;
	assign digit_hundred_k  = dig_q[5];
	assign digit_ten_k      = dig_q[4];
	assign digit_thousands  = dig_q[3];
	assign digit_hundreds   = dig_q[2];
	assign digit_tens       = dig_q[1];
	assign digit_ones       = dig_q[0];

endmodule

// File: hdl/dual_vfo_tuning_register.sv
// Dual VFO tuning register: one item is taken when start is high and busy is
// low, and exactly one result follows, shown for a single cycle with
// result_valid high; the receiver cannot stall it, so it must take the result
// in that cycle. A tune item passes through the add, subtract and clamp
// sequence, one step a cycle, before it commits; any other item goes straight
// to commit. Every item then passes the shift and the bit-serial binary to BCD
// converter, one bit a cycle, before the strobe. busy falls in the strobe
// cycle, so the next item may be accepted at the edge that ends it. Register
// writes are taken only while busy is low.
// Top level; depends on dvfo_pkg, dvfo_ctrl and dvfo_datapath.
module dual_vfo_tuning_register (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// item channel
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           mode,
	input  logic                                 vfo_index,
	input  logic                                 turn_up,
	input  logic                                 turn_down,
	input  logic [dvfo_pkg::FREQ_W-1:0]          load_freq,
	input  logic [1:0]                           offset_select,
	input  logic                                 transmit_on,
	// register write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dvfo_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dvfo_pkg::FREQ_W-1:0]          cfg_data,
	// result channel
	output logic                                 result_valid,
	output logic                                 reported_vfo,
	output logic [dvfo_pkg::FREQ_W-1:0]          dial_freq,
	output logic signed [dvfo_pkg::SHIFT_W-1:0]  shifted_freq,
	output logic                                 freq_changed,
	output logic                                 transmit_changed,
	output logic [6:0]                           digit_millions,
	output logic [3:0]                           digit_hundred_k,
	output logic [3:0]                           digit_ten_k,
	output logic [3:0]                           digit_thousands,
	output logic [3:0]                           digit_hundreds,
	output logic [3:0]                           digit_tens,
	output logic [3:0]                           digit_ones
);

	dvfo_pkg::cmd_t  cmd;
	dvfo_pkg::stat_t stat;

	// Take register writes only between items
	assign cfg_ready = ~busy;

	dvfo_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	dvfo_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.mode             (mode),
		.vfo_index        (vfo_index),
		.turn_up          (turn_up),
		.turn_down        (turn_down),
		.load_freq        (load_freq),
		.offset_select    (offset_select),
		.transmit_on      (transmit_on),
		.cfg_write        (cfg_valid & cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.result_valid     (result_valid),
		.reported_vfo     (reported_vfo),
		.dial_freq        (dial_freq),
		.shifted_freq     (shifted_freq),
		.freq_changed     (freq_changed),
		.transmit_changed (transmit_changed),
		.digit_millions   (digit_millions),
		.digit_hundred_k  (digit_hundred_k),
		.digit_ten_k      (digit_ten_k),
		.digit_thousands  (digit_thousands),
		.digit_hundreds   (digit_hundreds),
		.digit_tens       (digit_tens),
		.digit_ones       (digit_ones)
	);

endmodule

// File: hdl/dvfo_checker.sv
// Port-level checker of the dual VFO tuning register, bound to the top level.
// Depends on dvfo_pkg and dual_vfo_tuning_register_assert.svh.
`include "dual_vfo_tuning_register_assert.svh"

module dvfo_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        cfg_ready,
	input logic                        result_valid,
	input logic [dvfo_pkg::FREQ_W-1:0] dial_freq,
	input logic [6:0]                  digit_millions
);

	// An accepted item keeps the block busy
	`DVFO_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

	// A result strobe lasts one cycle
	`DVFO_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid)

	// The strobe comes as the block turns idle and opens the write port
	`DVFO_ASSERT_SAME(a_strobe_idle, result_valid, !busy && cfg_ready)

	// Reported frequency and its millions stay in range
	`DVFO_ASSERT_SAME(a_freq_range, result_valid,
		(dial_freq <= dvfo_pkg::FREQ_W'(dvfo_pkg::FREQ_MAX)) && (digit_millions <= 7'd99))

endmodule

bind dual_vfo_tuning_register dvfo_checker u_dvfo_checker (.*);
